// ===== hdl/bbc_pkg.sv =====
package bbc_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam logic [BYTE_W-1:0] CHAR_TERM         = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_OPEN_PAREN   = 8'h28;
	localparam logic [BYTE_W-1:0] CHAR_CLOSE_PAREN  = 8'h29;
	localparam logic [BYTE_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
	localparam logic [BYTE_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
	localparam logic [BYTE_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
	localparam logic [BYTE_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;

	localparam int KIND_W = 2;
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_PAREN  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_TERM
	} op_code_t;

	typedef struct packed {
		op_code_t code;
		kind_t    kind;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_beat_t;

	localparam int QUEUE_DEPTH = 4;

endpackage

// ===== hdl/bbc_if.sv =====
interface bbc_byte_if import bbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface bbc_result_if import bbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               balanced;
	logic [COUNT_W-1:0] unclosed_count;

	modport source (output valid, output balanced, output unclosed_count, input ready);
	modport sink (input valid, input balanced, input unclosed_count, output ready);
endinterface

// ===== hdl/bbc_ram.sv =====
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bbc_front.sv =====
module bbc_front import bbc_pkg::*; (
	bbc_byte_if.sink chars,
	input  logic     queue_full,
	output op_beat_t push
);

	logic  is_op;
	op_t   op;

	assign chars.ready = !queue_full;

	always_comb begin
		is_op   = 1'b1;
		op.code = OP_TERM;
		op.kind = KIND_PAREN;
		unique case (chars.byte_in)
			CHAR_TERM: begin
				op.code = OP_TERM;
			end
			CHAR_OPEN_PAREN: begin
				op.code = OP_PUSH;
				op.kind = KIND_PAREN;
			end
			CHAR_OPEN_SQUARE: begin
				op.code = OP_PUSH;
				op.kind = KIND_SQUARE;
			end
			CHAR_OPEN_CURLY: begin
				op.code = OP_PUSH;
				op.kind = KIND_CURLY;
			end
			CHAR_CLOSE_PAREN: begin
				op.code = OP_POP;
				op.kind = KIND_PAREN;
			end
			CHAR_CLOSE_SQUARE: begin
				op.code = OP_POP;
				op.kind = KIND_SQUARE;
			end
			CHAR_CLOSE_CURLY: begin
				op.code = OP_POP;
				op.kind = KIND_CURLY;
			end
			default: begin
				is_op = 1'b0;
			end
		endcase
	end

	// Bytes that are not brackets or the terminator are consumed here and never queued.
	assign push.valid = chars.valid && chars.ready && is_op;
	assign push.op    = op;

endmodule

// ===== hdl/bbc_fifo.sv =====
module bbc_fifo import bbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  op_beat_t push,
	input  logic     pop,
	output logic     full,
	output op_beat_t head
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           entries_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.op    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.op;
		end
	end

endmodule

// ===== hdl/bbc_back.sv =====
module bbc_back import bbc_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  op_beat_t head,
	output logic     pop,
	bbc_result_if.source result
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int SW  = (DW > COUNT_W) ? DW : COUNT_W;

	logic [DW-1:0]      depth_q;
	logic [DW-1:0]      depth_nxt;
	logic [DW-1:0]      depth_m2;
	logic               err_q;
	logic               err_nxt;
	kind_t              top_q;
	kind_t              top_nxt;
	kind_t              rd_data;
	logic               we;
	logic               slot_free;
	logic [SW-1:0]      depth_wide;
	logic [COUNT_W-1:0] count_sat;
	logic               res_valid_q;
	logic               balanced_q;
	logic [COUNT_W-1:0] count_q;

	assign slot_free = !res_valid_q || result.ready;
	assign pop       = head.valid && (head.op.code != OP_TERM || slot_free);

	always_comb begin
		depth_nxt = depth_q;
		err_nxt   = err_q;
		top_nxt   = top_q;
		we        = 1'b0;
		if (pop) begin
			unique case (head.op.code)
				OP_PUSH: begin
					if (depth_q == DW'(STACK_DEPTH)) begin
						err_nxt = 1'b1;
					end else begin
						we        = 1'b1;
						depth_nxt = depth_q + DW'(1);
						top_nxt   = head.op.kind;
					end
				end
				OP_POP: begin
					if (depth_q == '0 || top_q != head.op.kind) begin
						err_nxt = 1'b1;
					end else begin
						depth_nxt = depth_q - DW'(1);
						top_nxt   = rd_data;
					end
				end
				OP_TERM: begin
					depth_nxt = '0;
					err_nxt   = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// The read port always fetches the entry just below the next top, so a pop
	// in the following cycle finds it ready in rd_data.
	assign depth_m2 = depth_nxt - DW'(2);

	bbc_ram #(
		.WIDTH (KIND_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (depth_q[AW-1:0]),
		.wdata (head.op.kind),
		.raddr (depth_m2[AW-1:0]),
		.rdata (rd_data)
	);

	assign depth_wide = SW'(depth_q);
	assign count_sat  = (depth_wide > SW'(COUNT_MAX)) ? COUNT_MAX : depth_wide[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_nxt;
			err_q   <= err_nxt;
			if (pop && head.op.code == OP_TERM) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_nxt;
		if (pop && head.op.code == OP_TERM) begin
			balanced_q <= (depth_q == '0) && !err_q;
			count_q    <= count_sat;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.balanced       = balanced_q;
	assign result.unclosed_count = count_q;

	a_overflow_flags: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op.code == OP_PUSH && depth_q == DW'(STACK_DEPTH) |=> err_q)
		else $error("Push on a full stack did not set the error flag.");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op.code == OP_TERM |=> depth_q == '0 && !err_q && res_valid_q)
		else $error("Terminator did not clear the stack state and post a result.");

	a_match_pops: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op.code == OP_POP && depth_q != '0 && top_q == head.op.kind
		|=> depth_q == $past(depth_q) - DW'(1))
		else $error("Matching closer did not pop the stack.");

	a_term_waits: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid && head.op.code == OP_TERM && res_valid_q && !result.ready |-> !pop)
		else $error("Terminator executed while the result register was still occupied.");

endmodule

// ===== hdl/bracket_balance_checker.sv =====
// Balanced-bracket checker. Bytes arrive on chars, one per beat; byte 0 ends a string and
// produces one beat on result with the balanced flag and the number of openers left open
// (saturating at 127). Closers that do not match the top opener or arrive on an empty
// stack, and openers beyond STACK_DEPTH, mark the string unbalanced. The block takes one
// byte per cycle while the queue is not full; the stack back end executes one bracket
// operation per cycle unless a terminator waits for result, with the top of stack in a
// register and the stack RAM, one write and one read port, prefetching the entry beneath.
// A terminator passes through the four-entry operation queue and the result register to
// reach result. A result still waiting on result holds back the next terminator; chars
// stalls once four operations wait in the queue. No stack clearing is needed after reset.
module bracket_balance_checker import bbc_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	bbc_byte_if.sink     chars,
	bbc_result_if.source result
);

	op_beat_t push;
	op_beat_t head;
	logic     queue_full;
	logic     pop;

	bbc_front u_front (
		.chars      (chars),
		.queue_full (queue_full),
		.push       (push)
	);

	bbc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
